// ===== src/ubx_nav_pkg.sv =====
// Shared constants and types for the UBX NAV frame parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ubx_nav_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SEL_W  = 2;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // Frame constants
    localparam logic [BYTE_W-1:0] SYNC_CHAR1 = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_CHAR2 = 8'h62;
    localparam logic [BYTE_W-1:0] CLASS_NAV  = 8'h01;
    localparam logic [BYTE_W-1:0] ID_POSLLH  = 8'h02;
    localparam logic [BYTE_W-1:0] ID_SOL     = 8'h06;
    localparam logic [BYTE_W-1:0] ID_VELNED  = 8'h12;

    // Checksum seed after class byte: A = class, B = class + class
    localparam logic [BYTE_W-1:0] CK_SEED_A = CLASS_NAV;
    localparam logic [BYTE_W-1:0] CK_SEED_B = CLASS_NAV + CLASS_NAV;

    // Buffer select codes
    localparam logic [SEL_W-1:0] SEL_POSITION = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SOLUTION = 2'd1;
    localparam logic [SEL_W-1:0] SEL_VELOCITY = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SOLUTION_CAP = 2'd0;
    localparam logic [IDX_W-1:0] REG_POSITION_CAP = 2'd1;
    localparam logic [IDX_W-1:0] REG_VELOCITY_CAP = 2'd2;

    // Capacity reset values
    localparam logic [BYTE_W-1:0] SOLUTION_CAP_RST = 8'd53;
    localparam logic [BYTE_W-1:0] POSITION_CAP_RST = 8'd29;
    localparam logic [BYTE_W-1:0] VELOCITY_CAP_RST = 8'd37;

    // Parser phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_SYNC1 = 9'b000000010,
        PH_SYNC2 = 9'b000000100,
        PH_CLASS = 9'b000001000,
        PH_LEN1  = 9'b000010000,
        PH_LEN2  = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CKA   = 9'b010000000,
        PH_CKB   = 9'b100000000
    } phase_t;

    // One parser result word
    typedef struct packed {
        logic              write_enable;
        logic              status_enable;
        logic [SEL_W-1:0]  message_select;
        logic [BYTE_W-1:0] byte_offset;
        logic [BYTE_W-1:0] byte_value;
        logic              status_new;
    } result_t;

endpackage

// ===== src/ubx_nav_if.sv =====
// Valid/ready channel interfaces for the UBX NAV frame parser.
// Depends on ubx_nav_pkg.
`timescale 1ns / 1ps

interface ubx_nav_rx_if;
    import ubx_nav_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_nav_res_if;
    import ubx_nav_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_enable;
    logic              status_enable;
    logic [SEL_W-1:0]  message_select;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] byte_value;
    logic              status_new;

    modport source (output valid, output write_enable, output status_enable,
                    output message_select, output byte_offset, output byte_value,
                    output status_new, input ready);
    modport sink   (input valid, input write_enable, input status_enable,
                    input message_select, input byte_offset, input byte_value,
                    input status_new, output ready);
endinterface

// ===== src/ubx_nav_frame_parser.sv =====
// Top level of the UBX NAV frame parser: input stage, parse logic, result register.
// Depends on ubx_nav_pkg and the channel interfaces in ubx_nav_if.sv.
`timescale 1ns / 1ps

// Frames UBX NAV messages (class 01, ids 02/06/12) from a byte stream and emits
// one result word per received byte: a buffer write with offset and value, a
// buffer status update (invalid when the length is in, new or invalid after the
// checksum), or an empty word. The parser takes one byte per clock when the
// result side keeps up; each accepted byte passes from an input register through
// a single stage of parse logic, which also updates the frame state, into a
// result register. Capacity registers may only be written while no byte is in
// flight.
module ubx_nav_frame_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ubx_nav_pkg::IDX_W-1:0] cfg_index,
    input  logic [ubx_nav_pkg::BYTE_W-1:0] cfg_data,
    ubx_nav_rx_if.sink                    rx,
    ubx_nav_res_if.source                 res
);
    import ubx_nav_pkg::*;

    // Capacity registers
    logic [BYTE_W-1:0] sol_cap_reg;
    logic [BYTE_W-1:0] pos_cap_reg;
    logic [BYTE_W-1:0] vel_cap_reg;

    // Input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Frame state
    phase_t            phase_reg,  phase_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [BYTE_W-1:0] sum_a_reg,  sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg,  sum_b_next;
    logic [SEL_W-1:0]  sel_reg,    sel_next;
    logic [BYTE_W-1:0] offset_reg, offset_next;

    // Result stage
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;

    logic              advance;
    logic [BYTE_W-1:0] cap_sel;
    logic [BYTE_W-1:0] add_a;
    logic [BYTE_W-1:0] add_b;
    logic [LEN_W-1:0]  remain_dec;

    // Handshake: process a held byte when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    // Write capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sol_cap_reg <= SOLUTION_CAP_RST;
            pos_cap_reg <= POSITION_CAP_RST;
            vel_cap_reg <= VELOCITY_CAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOLUTION_CAP: sol_cap_reg <= cfg_data;
                REG_POSITION_CAP: pos_cap_reg <= cfg_data;
                REG_VELOCITY_CAP: vel_cap_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Pick the capacity of the selected buffer
    always_comb
    begin
        case (sel_reg)
            SEL_SOLUTION: cap_sel = sol_cap_reg;
            SEL_VELOCITY: cap_sel = vel_cap_reg;
            default:      cap_sel = pos_cap_reg;
        endcase
    end

    // Fletcher step and length countdown
    assign add_a      = sum_a_reg + in_byte_reg;
    assign add_b      = sum_b_reg + add_a;
    assign remain_dec = remain_reg - LEN_W'(1);

    // Parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        sel_next    = sel_reg;
        offset_next = offset_reg;
        result      = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                phase_next = (in_byte_reg == SYNC_CHAR1) ? PH_SYNC1 : PH_IDLE;
            end
            PH_SYNC1:
            begin
                phase_next = (in_byte_reg == SYNC_CHAR2) ? PH_SYNC2 : PH_IDLE;
            end
            PH_SYNC2:
            begin
                phase_next = (in_byte_reg == CLASS_NAV) ? PH_CLASS : PH_IDLE;
            end
            PH_CLASS:
            begin
                if (in_byte_reg inside {ID_POSLLH, ID_SOL, ID_VELNED})
                begin
                    if (in_byte_reg == ID_POSLLH)
                        sel_next = SEL_POSITION;
                    else if (in_byte_reg == ID_SOL)
                        sel_next = SEL_SOLUTION;
                    else
                        sel_next = SEL_VELOCITY;
                    // restart checksum with class and id folded in
                    sum_a_next  = CK_SEED_A + in_byte_reg;
                    sum_b_next  = CK_SEED_B + in_byte_reg;
                    offset_next = '0;
                    phase_next  = PH_LEN1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LEN1:
            begin
                remain_next = {{(LEN_W-BYTE_W){1'b0}}, in_byte_reg};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = PH_LEN2;
            end
            PH_LEN2:
            begin
                remain_next = {in_byte_reg, remain_reg[BYTE_W-1:0]};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                // mark buffer invalid while the payload streams in
                result.status_enable  = 1'b1;
                result.message_select = sel_reg;
                phase_next = ({in_byte_reg, remain_reg[BYTE_W-1:0]} == '0) ? PH_CKA : PH_DATA;
            end
            PH_DATA:
            begin
                if (offset_reg < cap_sel)
                begin
                    result.write_enable   = 1'b1;
                    result.message_select = sel_reg;
                    result.byte_offset    = offset_reg;
                    result.byte_value     = in_byte_reg;
                    offset_next = offset_reg + BYTE_W'(1);
                    sum_a_next  = add_a;
                    sum_b_next  = add_b;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                        phase_next = PH_CKA;
                end
                else
                begin
                    // overrun: drop the frame, status stays invalid
                    phase_next = PH_IDLE;
                end
            end
            PH_CKA:
            begin
                if (in_byte_reg == sum_a_reg)
                begin
                    phase_next = PH_CKB;
                end
                else
                begin
                    result.status_enable  = 1'b1;
                    result.message_select = sel_reg;
                    phase_next = PH_IDLE;
                end
            end
            PH_CKB:
            begin
                result.status_enable  = 1'b1;
                result.status_new     = (in_byte_reg == sum_b_reg);
                result.message_select = sel_reg;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance frame state with each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            remain_reg <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            sel_reg    <= SEL_POSITION;
            offset_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            sel_reg    <= sel_next;
            offset_reg <= offset_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.write_enable   = out_reg.write_enable;
    assign res.status_enable  = out_reg.status_enable;
    assign res.message_select = out_reg.message_select;
    assign res.byte_offset    = out_reg.byte_offset;
    assign res.byte_value     = out_reg.byte_value;
    assign res.status_new     = out_reg.status_new;

`ifndef SYNTHESIS
    // A word never both writes a byte and updates status
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.write_enable && res.status_enable))
        else $error("write and status update in one word");

    // Stored bytes stay inside the selected buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.write_enable |-> result.byte_offset < cap_sel)
        else $error("payload write beyond buffer capacity");

    // A new-data status only follows a matching first checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.status_new |-> phase_reg == PH_CKB)
        else $error("new status outside second checksum byte");

    // Payload writes only happen while a frame payload is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.write_enable |-> remain_reg != '0)
        else $error("payload write with no length remaining");
`endif

endmodule
